// File: rtl/core/dzq_pkg.sv
// Package for the distance zone qualifier: payload types, widths, codes and constants.
package dzq_pkg;

  localparam int DIST_W    = 25;
  localparam int CNT_W     = 4;
  localparam int ECHO_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int SEQ_W     = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_LOW       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_HIGH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_LOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_HIGH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_QUALIFY_COUNT = 3'd6;

  // Register reset values
  localparam logic [DIST_W-1:0] NEAR_LIMIT_RST    = 25'd1700;
  localparam logic [DIST_W-1:0] MID_LOW_RST       = 25'd1800;
  localparam logic [DIST_W-1:0] MID_HIGH_RST      = 25'd4500;
  localparam logic [DIST_W-1:0] FAR_LOW_RST       = 25'd4600;
  localparam logic [DIST_W-1:0] FAR_HIGH_RST      = 25'd6300;
  localparam logic [DIST_W-1:0] STOP_LIMIT_RST    = 25'd6500;
  localparam logic [CNT_W-1:0]  QUALIFY_COUNT_RST = 4'd3;

  // Band / display sequence codes
  localparam logic [SEQ_W-1:0] SEQ_NEAR = 2'd0;
  localparam logic [SEQ_W-1:0] SEQ_MID  = 2'd1;
  localparam logic [SEQ_W-1:0] SEQ_FAR  = 2'd2;
  localparam logic [SEQ_W-1:0] SEQ_STOP = 2'd3;
  localparam logic [SEQ_W-1:0] SHOWN_NONE = SEQ_STOP;

  // Request types
  localparam logic REQ_ECHO = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // distance = t*340/80000 = floor(floor(t*17/32) / 125)
  // The divide by 125 uses a reciprocal that is at most one low, then one correction.
  localparam int                PRE_SHIFT   = 5;
  localparam int                RECIP_SHIFT = 38;
  localparam logic [31:0]       RECIP_125   = 32'd2199023255; // floor(2^38 / 125)
  localparam logic [32:0]       DIV_125     = 33'd125;

  typedef struct packed {
    logic              req_type;
    logic [ECHO_W-1:0] echo_time;
  } in_item_t;

  typedef struct packed {
    logic              fired;
    logic [SEQ_W-1:0]  sequence_res;
    logic              stopped;
    logic [DIST_W-1:0] distance;
  } out_item_t;

  // Item leaving the conversion pipeline
  typedef struct packed {
    logic              req_type;
    logic [DIST_W-1:0] distance;
  } conv_item_t;

  // Configuration register bank
  typedef struct packed {
    logic [DIST_W-1:0] near_limit;
    logic [DIST_W-1:0] mid_low;
    logic [DIST_W-1:0] mid_high;
    logic [DIST_W-1:0] far_low;
    logic [DIST_W-1:0] far_high;
    logic [DIST_W-1:0] stop_limit;
    logic [CNT_W-1:0]  qualify_count;
  } cfg_regs_t;

endpackage

// File: rtl/core/dzq_convert.sv
// Three-stage pipeline that converts an echo time into a distance.
module dzq_convert
  import dzq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_stall,
  input  in_item_t   up_data,
  output logic       dn_valid,
  input  logic       dn_stall,
  output conv_item_t dn_data
);

  // Stage valids and per-stage ready
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // Stage 1: t*17/32
  logic              s1_req;
  logic [31:0]       s1_q1;
  logic [36:0]       t17;

  // Stage 2: reciprocal product
  logic              s2_req;
  logic [31:0]       s2_q1;
  logic [63:0]       prod;
  logic [25:0]       s2_qest;

  // Stage 3: corrected quotient
  logic [32:0]       q125;
  logic [32:0]       rem;
  logic [25:0]       qfix;
  conv_item_t        s3;

  assign rdy3     = !v3 || !dn_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign up_stall = !rdy1;

  assign t17  = {up_data.echo_time, 4'b0} + {5'b0, up_data.echo_time};
  assign prod = {32'b0, s1_q1} * {32'b0, RECIP_125};

  // Estimate is exact or one low; fix with one compare
  assign q125 = {7'b0, s2_qest} * DIV_125;
  assign rem  = {1'b0, s2_q1} - q125;
  assign qfix = (rem >= DIV_125) ? s2_qest + 26'd1 : s2_qest;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_req <= up_data.req_type;
      s1_q1  <= t17[36:PRE_SHIFT];
    end
    if (rdy2) begin
      s2_req  <= s1_req;
      s2_q1   <= s1_q1;
      s2_qest <= prod[RECIP_SHIFT+25:RECIP_SHIFT];
    end
    if (rdy3) begin
      s3.req_type <= s2_req;
      s3.distance <= qfix[DIST_W-1:0];
    end
  end

  assign dn_valid = v3;
  assign dn_data  = s3;

endmodule

// File: rtl/core/dzq_zone.sv
// Zone state: band classification, qualify counters, shown sequence and result register.
module dzq_zone
  import dzq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_regs_t  cfg,
  input  logic       up_valid,
  output logic       up_stall,
  input  conv_item_t up_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  logic [DIST_W-1:0] cur_dist, cur_dist_next;
  logic              seen, seen_next;
  logic [CNT_W-1:0]  cnt [4];
  logic [CNT_W-1:0]  cnt_next [4];
  logic [SEQ_W-1:0]  shown_band, shown_band_next;
  logic              stop_flag, stop_flag_next;
  logic              fired_next;
  logic [SEQ_W-1:0]  seq_next;

  logic              near_hit, mid_hit, far_hit, stop_hit, take;
  logic [SEQ_W-1:0]  band;
  logic [CNT_W-1:0]  bumped;
  logic              load;

  assign up_stall = out_valid && out_stall;
  assign load     = up_valid && !up_stall;

  // Band tests on the held distance, in priority order
  assign near_hit = (cur_dist < cfg.near_limit) && (shown_band != SEQ_NEAR);
  assign mid_hit  = (cfg.mid_low < cur_dist) && (cur_dist < cfg.mid_high)
                    && (shown_band != SEQ_MID);
  assign far_hit  = (cfg.far_low < cur_dist) && (cur_dist < cfg.far_high)
                    && (shown_band != SEQ_FAR);
  assign stop_hit = cur_dist > cfg.stop_limit;

  always_comb begin
    take = 1'b1;
    if (near_hit)     band = SEQ_NEAR;
    else if (mid_hit) band = SEQ_MID;
    else if (far_hit) band = SEQ_FAR;
    else begin
      band = SEQ_STOP;
      take = stop_hit;
    end
  end

  assign bumped = cnt[band] + 4'd1;

  // Next state for one item
  always_comb begin
    cur_dist_next   = cur_dist;
    seen_next       = seen;
    shown_band_next = shown_band;
    stop_flag_next  = stop_flag;
    fired_next      = 1'b0;
    seq_next        = SEQ_NEAR;
    for (int k = 0; k < 4; k++) cnt_next[k] = cnt[k];

    if (!stop_flag) begin
      if (up_data.req_type == REQ_ECHO) begin
        if (seen) cur_dist_next = up_data.distance;
        seen_next = 1'b1;
      end else if (take) begin
        if (bumped == cfg.qualify_count) begin
          cnt_next[band] = '0;
          fired_next     = 1'b1;
          seq_next       = band;
          if (band == SEQ_STOP) stop_flag_next  = 1'b1;
          else                  shown_band_next = band;
        end else begin
          for (int k = 0; k < 4; k++) cnt_next[k] = '0;
          cnt_next[band] = bumped;
        end
      end
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_dist   <= '0;
      seen       <= 1'b0;
      shown_band <= SHOWN_NONE;
      stop_flag  <= 1'b0;
      out_valid  <= 1'b0;
      for (int k = 0; k < 4; k++) cnt[k] <= '0;
    end else begin
      if (!up_stall) out_valid <= up_valid;
      if (load) begin
        cur_dist   <= cur_dist_next;
        seen       <= seen_next;
        shown_band <= shown_band_next;
        stop_flag  <= stop_flag_next;
        for (int k = 0; k < 4; k++) cnt[k] <= cnt_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.fired        <= fired_next;
      out_data.sequence_res <= seq_next;
      out_data.stopped      <= stop_flag_next;
      out_data.distance     <= cur_dist_next;
    end
  end

  // Stop is sticky until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stop_flag |=> stop_flag)
    else $error("stop flag cleared without reset");

  // A blank sequence result always reports the block stopped
  a_stop_fire: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fired && (out_data.sequence_res == SEQ_STOP) |-> out_data.stopped)
    else $error("stop fired but block not stopped");

  // A non-firing result carries sequence zero
  a_idle_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.fired |-> (out_data.sequence_res == SEQ_NEAR))
    else $error("sequence set without fire");

  // A fired display band is the one now shown
  a_shown: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fired && (out_data.sequence_res != SEQ_STOP)
    |-> (shown_band == out_data.sequence_res))
    else $error("fired band not recorded as shown");

endmodule

// File: rtl/core/distance_zone_qualifier_unit.sv
// Stages: 3 conversion stages and 1 zone stage between input transfer and result.
// Throughput: one item per cycle unless out_stall holds it; the reciprocal multiply
// and its correction are pipelined ahead of the zone state, outside its state loop.
// Reset (rst, synchronous): limits return to defaults, counters clear, no sequence
// shown, not stopped, pipeline empty. No clearing pass is needed.
// Top level: configuration registers, echo conversion pipeline and zone state.
module distance_zone_qualifier_unit
  import dzq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data
);

  cfg_regs_t  cfg;
  logic       conv_valid;
  logic       conv_stall;
  conv_item_t conv_data;

  assign cfg_ready = 1'b1;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_limit    <= NEAR_LIMIT_RST;
      cfg.mid_low       <= MID_LOW_RST;
      cfg.mid_high      <= MID_HIGH_RST;
      cfg.far_low       <= FAR_LOW_RST;
      cfg.far_high      <= FAR_HIGH_RST;
      cfg.stop_limit    <= STOP_LIMIT_RST;
      cfg.qualify_count <= QUALIFY_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NEAR_LIMIT:    cfg.near_limit    <= cfg_data;
        REG_MID_LOW:       cfg.mid_low       <= cfg_data;
        REG_MID_HIGH:      cfg.mid_high      <= cfg_data;
        REG_FAR_LOW:       cfg.far_low       <= cfg_data;
        REG_FAR_HIGH:      cfg.far_high      <= cfg_data;
        REG_STOP_LIMIT:    cfg.stop_limit    <= cfg_data;
        REG_QUALIFY_COUNT: cfg.qualify_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  dzq_convert u_convert (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (in_data),
    .dn_valid (conv_valid),
    .dn_stall (conv_stall),
    .dn_data  (conv_data)
  );

  dzq_zone u_zone (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .up_valid  (conv_valid),
    .up_stall  (conv_stall),
    .up_data   (conv_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the distance zone qualifier: directed and random echo/tick traffic checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import dzq_pkg::*;

  localparam longint unsigned MAX_DIST = 18253611;
  localparam longint unsigned MAX_REG  = 25'h1FFFFFF;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIST_W-1:0]    cfg_data = '0;

  distance_zone_qualifier_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Predictor copy of the limits and the zone state
  cfg_regs_t         lim;
  logic [DIST_W-1:0] cur_dist;
  bit                echo_primed;
  logic [CNT_W-1:0]  band_cnt [4];
  logic [SEQ_W-1:0]  shown_seq;
  bit                halted;

  in_item_t  req_q [$];        // items waiting to be offered
  out_item_t zone_verdicts [$]; // predicted results, oldest first

  int unsigned taken_count = 0;
  int unsigned err_count = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned src_pct = 0;
  int unsigned sink_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;
  bit          calm = 1'b0;

  // Advance the taken band's counter; 1 when it reaches the qualify count
  function automatic bit bump_band(logic [SEQ_W-1:0] b);
    band_cnt[b] = band_cnt[b] + 1'b1;
    if (band_cnt[b] == lim.qualify_count) begin
      band_cnt[b] = '0;
      return 1'b1;
    end
    for (int k = 0; k < 4; k++)
      if (k != b) band_cnt[k] = '0;
    return 1'b0;
  endfunction

  // Expected result of one accepted item; updates the predictor state
  function automatic out_item_t zone_predict(in_item_t it);
    out_item_t        r;
    logic [63:0]      prod;
    logic [SEQ_W-1:0] take;
    bit               hit;
    r = '0;
    hit = 1'b0;
    take = SEQ_NEAR;
    if (!halted) begin
      if (it.req_type == REQ_ECHO) begin
        prod = 64'(it.echo_time) * 64'd340 / 64'd80000;
        if (echo_primed) cur_dist = prod[DIST_W-1:0];
        echo_primed = 1'b1;
      end else begin
        if (cur_dist < lim.near_limit && shown_seq != SEQ_NEAR) begin
          hit = 1'b1; take = SEQ_NEAR;
        end else if (lim.mid_low < cur_dist && cur_dist < lim.mid_high
                     && shown_seq != SEQ_MID) begin
          hit = 1'b1; take = SEQ_MID;
        end else if (lim.far_low < cur_dist && cur_dist < lim.far_high
                     && shown_seq != SEQ_FAR) begin
          hit = 1'b1; take = SEQ_FAR;
        end else if (cur_dist > lim.stop_limit) begin
          hit = 1'b1; take = SEQ_STOP;
        end
        if (hit && bump_band(take)) begin
          r.fired = 1'b1;
          r.sequence_res = take;
          if (take == SEQ_STOP) halted = 1'b1;
          else shown_seq = take;
        end
      end
    end
    r.stopped = halted;
    r.distance = cur_dist;
    return r;
  endfunction

  // Driver: offers queued items, holds a stalled transfer, idles in bursts
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        zone_verdicts.push_back(zone_predict(in_data));
        taken_count <= taken_count + 1;
      end
      if (in_valid && in_stall) begin
        // payload must stay put
      end else if (src_gap != 0) begin
        in_valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (req_q.size() != 0) begin
        if (!calm && $urandom_range(0, 99) < src_pct) begin
          in_valid <= 1'b0;
          src_gap <= $urandom_range(0, 18);
        end else begin
          in_valid <= 1'b1;
          in_data <= req_q.pop_front();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off so the pipeline backs up into the input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && taken_count == 300) begin
      hold_left <= 300;
      hold_used <= 1'b1;
    end
  end

  // Monitor: checks each result transfer, stalls in bursts
  always @(posedge clk) begin : sink_proc
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (zone_verdicts.size() == 0) begin
          if (err_count < 10)
            $display("%0t unexpected result fired=%0d seq=%0d stopped=%0d dist=%0d", $time,
                     out_data.fired, out_data.sequence_res, out_data.stopped,
                     out_data.distance);
          err_count++;
        end else begin
          want = zone_verdicts.pop_front();
          if (want.fired !== out_data.fired || want.sequence_res !== out_data.sequence_res
              || want.stopped !== out_data.stopped || want.distance !== out_data.distance)
          begin
            if (err_count < 10)
              $display("%0t mismatch: exp fired=%0d seq=%0d stopped=%0d dist=%0d, got %0d %0d %0d %0d",
                       $time, want.fired, want.sequence_res, want.stopped, want.distance,
                       out_data.fired, out_data.sequence_res, out_data.stopped,
                       out_data.distance);
            err_count++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (sink_gap != 0) begin
        out_stall <= 1'b1;
        sink_gap <= sink_gap - 1;
      end else if (!calm && $urandom_range(0, 99) < sink_pct) begin
        out_stall <= 1'b1;
        sink_gap <= $urandom_range(0, 18);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Echo time whose converted distance is exactly d
  function automatic logic [ECHO_W-1:0] echo_for(longint unsigned d);
    longint unsigned t;
    t = (d * 4000 + 16) / 17;
    return t[ECHO_W-1:0];
  endfunction

  function automatic void add_echo(logic [ECHO_W-1:0] t);
    in_item_t it;
    it.req_type = REQ_ECHO;
    it.echo_time = t;
    req_q.push_back(it);
  endfunction

  // Ticks carry random junk in the unused echo field
  function automatic void add_tick();
    in_item_t it;
    it.req_type = REQ_TICK;
    it.echo_time = $urandom;
    req_q.push_back(it);
  endfunction

  // Random distance strictly between lo and hi; fallback anywhere
  function automatic longint unsigned in_span(longint unsigned lo, longint unsigned hi);
    if (hi > MAX_DIST + 1) hi = MAX_DIST + 1;
    if (hi > lo + 1) return lo + 1 + $urandom_range(0, hi - lo - 2);
    return $urandom_range(0, MAX_DIST);
  endfunction

  // Distance aimed at a band, sometimes right on a limit
  function automatic longint unsigned pick_dist(int band);
    longint unsigned edges [6];
    longint unsigned v;
    if ($urandom_range(0, 4) == 0) begin
      edges = '{lim.near_limit, lim.mid_low, lim.mid_high,
                lim.far_low, lim.far_high, lim.stop_limit};
      v = edges[$urandom_range(0, 5)] + $urandom_range(0, 2);
      v = (v == 0) ? 0 : v - 1;
      return (v > MAX_DIST) ? MAX_DIST : v;
    end
    case (band)
      SEQ_NEAR: begin
        if (lim.near_limit == 0) return $urandom_range(0, MAX_DIST);
        v = lim.near_limit - 1;
        return $urandom_range(0, (v > MAX_DIST) ? MAX_DIST : v);
      end
      SEQ_MID: return in_span(lim.mid_low, lim.mid_high);
      SEQ_FAR: return in_span(lim.far_low, lim.far_high);
      default: begin
        if (lim.stop_limit < MAX_DIST) return $urandom_range(lim.stop_limit + 1, MAX_DIST);
        return $urandom_range(0, MAX_DIST);
      end
    endcase
  endfunction

  // Mostly echo-then-ticks runs aimed at a band; the rest raw echoes and stray ticks
  task automatic gen_items(int unsigned n);
    int unsigned cnt;
    int unsigned r;
    int unsigned k;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        add_echo(echo_for(pick_dist($urandom_range(0, 3))));
        k = $urandom_range(1, lim.qualify_count + 2);
        repeat (k) add_tick();
        cnt += k + 1;
      end else if (r < 85) begin
        add_echo($urandom);
        cnt++;
      end else begin
        k = $urandom_range(1, 3);
        repeat (k) add_tick();
        cnt += k;
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[DIST_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NEAR_LIMIT:    lim.near_limit = val[DIST_W-1:0];
      REG_MID_LOW:       lim.mid_low = val[DIST_W-1:0];
      REG_MID_HIGH:      lim.mid_high = val[DIST_W-1:0];
      REG_FAR_LOW:       lim.far_low = val[DIST_W-1:0];
      REG_FAR_HIGH:      lim.far_high = val[DIST_W-1:0];
      REG_STOP_LIMIT:    lim.stop_limit = val[DIST_W-1:0];
      REG_QUALIFY_COUNT: lim.qualify_count = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(longint unsigned nl, longint unsigned ml, longint unsigned mh,
                          longint unsigned fl, longint unsigned fh, longint unsigned sl,
                          longint unsigned q);
    write_reg(REG_NEAR_LIMIT, nl);
    write_reg(REG_MID_LOW, ml);
    write_reg(REG_MID_HIGH, mh);
    write_reg(REG_FAR_LOW, fl);
    write_reg(REG_FAR_HIGH, fh);
    write_reg(REG_STOP_LIMIT, sl);
    write_reg(REG_QUALIFY_COUNT, q);
  endtask

  // Random limits, usually in order, stop band out of reach
  task automatic rand_scheme();
    int unsigned v [$];
    int unsigned span;
    span = ($urandom_range(0, 3) == 0) ? MAX_REG : 8000;
    repeat (5) v.push_back($urandom_range(0, span));
    if ($urandom_range(0, 3) != 0) v.sort();
    set_regs(v[0], v[1], v[2], v[3], v[4], MAX_REG, $urandom_range(1, 15));
  endtask

  // Idle rates for one phase: none, light or heavy per side
  task automatic pace();
    int unsigned rates [3];
    rates = '{0, 10, 35};
    src_pct <= rates[$urandom_range(0, 2)];
    sink_pct <= rates[$urandom_range(0, 2)];
  endtask

  // Wait until every offered item has produced its result
  task automatic drain();
    do @(negedge clk);
    while (req_q.size() != 0 || in_valid || zone_verdicts.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Stimulus
  initial begin
    lim = '{NEAR_LIMIT_RST, MID_LOW_RST, MID_HIGH_RST, FAR_LOW_RST, FAR_HIGH_RST,
            STOP_LIMIT_RST, QUALIFY_COUNT_RST};
    cur_dist = '0;
    echo_primed = 1'b0;
    for (int k = 0; k < 4; k++) band_cnt[k] = '0;
    shown_seq = SHOWN_NONE;
    halted = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    pace();

    // Directed: discarded first echo, each display band firing, skips, gaps and limit edges
    add_echo('1);
    repeat (4) add_tick();
    add_echo('1);
    add_echo(echo_for(3000));
    repeat (2) add_tick();
    add_echo(echo_for(1750));
    add_tick();
    add_echo(echo_for(3000));
    add_tick();
    add_echo(echo_for(5000));
    add_tick();
    add_echo('0);
    add_tick();
    add_echo(echo_for(5000));
    repeat (3) add_tick();
    add_echo(echo_for(1700));
    add_tick();
    add_echo(echo_for(6500));
    add_tick();
    drain();

    // Extreme limits: middle and far bands both span everything, then everything near
    set_regs(0, 0, MAX_REG, 0, MAX_REG, MAX_REG, 1);
    pace();
    gen_items(100);
    drain();
    set_regs(MAX_REG, MAX_REG, 0, MAX_REG, 0, MAX_REG, 15);
    pace();
    gen_items(60);
    drain();

    repeat (4) begin
      rand_scheme();
      pace();
      gen_items(130);
      drain();
    end

    // Last phase: no idling, stop band within reach
    calm <= 1'b1;
    set_regs(NEAR_LIMIT_RST, MID_LOW_RST, MID_HIGH_RST, FAR_LOW_RST, FAR_HIGH_RST,
             ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8000),
             $urandom_range(1, 15));
    gen_items(80);
    drain();

    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
